FILE: hw/rtl/lbfg_pkg.sv
// package for the load based frequency governor
// shared widths, constants, command codes and controller/datapath structs
// no dependencies
package lbfg_pkg;

  localparam int unsigned KhzW     = 22;
  localparam int unsigned UsW      = 32;
  localparam int unsigned PctW     = 7;
  localparam int unsigned HoldW    = 27;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 27;
  localparam int unsigned NumW     = 39;   // 100 * 32-bit time
  localparam int unsigned DivSteps = 7;    // quotient bits, load is at most 100
  localparam int unsigned DivCntW  = 3;
  localparam int unsigned ReqW     = 24;   // signed request, covers cur + step and cur - step

  // item kinds
  localparam logic KindSample = 1'b0;
  localparam logic KindEvent  = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgPolicyMin = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgPolicyMax = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgUpPct     = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgDownPct   = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgUpStep    = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgDownHold  = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgIowBusy   = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgNiceIdle  = 4'd7;

  // register reset values
  localparam logic [KhzW-1:0]  RstPolicyMin = 22'd204000;
  localparam logic [KhzW-1:0]  RstPolicyMax = 22'd1500000;
  localparam logic [PctW-1:0]  RstUpPct     = 7'd96;
  localparam logic [PctW-1:0]  RstDownPct   = 7'd40;
  localparam logic [KhzW-1:0]  RstUpStep    = 22'd51000;
  localparam logic [HoldW-1:0] RstDownHold  = 27'd30000;

  // mode constants
  localparam logic [KhzW-1:0] AwakeIdealKhz    = 22'd910000;
  localparam logic [KhzW-1:0] SleepIdealKhz    = 22'd640000;
  localparam logic [PctW-1:0] SleepUpPct       = 7'd65;
  localparam logic [PctW-1:0] SleepDownPct     = 7'd15;
  localparam logic [KhzW-1:0] SleepDownStepKhz = 22'd436000;
  localparam logic [KhzW-1:0] AwakeDownStepKhz = 22'd51000;
  localparam logic [UsW-1:0]  AwakeUpHoldUs    = 32'd90000;
  localparam logic [UsW-1:0]  SleepUpHoldUs    = 32'd30000;
  localparam logic [KhzW-1:0] BoostFloorKhz    = 22'd910000;
  localparam logic [PctW-1:0] FullPct          = 7'd100;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EVENT,
    OP_SUM,
    OP_ADJ,
    OP_DIFF,
    OP_MUL,
    OP_DIV,
    OP_IDEAL,
    OP_DIR,
    OP_REQ,
    OP_CLAMP,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [DivCntW-1:0] div_sh;
  } cmd_t;

  typedef struct packed {
    logic has_req;
  } sts_t;

endpackage

FILE: hw/rtl/lbfg_ctrl.sv
// sequencer for the frequency governor
// walks the datapath through one sample and owns the output valid flag
// depends on lbfg_pkg
module lbfg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            kind_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lbfg_pkg::cmd_t  cmd_o,
  input  lbfg_pkg::sts_t  sts_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_ADJ,
    S_DIFF,
    S_MUL,
    S_DIV,
    S_IDEAL,
    S_DIR,
    S_REQ,
    S_CLAMP,
    S_EMIT
  } state_e;

  state_e                       state_q;
  logic [lbfg_pkg::DivCntW-1:0] div_q;
  logic                         out_valid_q;
  logic                         emit_ok;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign emit_ok     = sts_i.has_req && (!out_valid_q || !out_stall_i);

  always_comb begin
    cmd_o.op     = lbfg_pkg::OP_NONE;
    cmd_o.div_sh = div_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = (kind_i == lbfg_pkg::KindEvent) ? lbfg_pkg::OP_EVENT : lbfg_pkg::OP_LOAD;
        end
      end
      S_SUM:   cmd_o.op = lbfg_pkg::OP_SUM;
      S_ADJ:   cmd_o.op = lbfg_pkg::OP_ADJ;
      S_DIFF:  cmd_o.op = lbfg_pkg::OP_DIFF;
      S_MUL:   cmd_o.op = lbfg_pkg::OP_MUL;
      S_DIV:   cmd_o.op = lbfg_pkg::OP_DIV;
      S_IDEAL: cmd_o.op = lbfg_pkg::OP_IDEAL;
      S_DIR:   cmd_o.op = lbfg_pkg::OP_DIR;
      S_REQ:   cmd_o.op = lbfg_pkg::OP_REQ;
      S_CLAMP: cmd_o.op = lbfg_pkg::OP_CLAMP;
      S_EMIT: begin
        if (emit_ok) begin
          cmd_o.op = lbfg_pkg::OP_EMIT;
        end
      end
      default: cmd_o.op = lbfg_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new word replaces the old one, else the old one leaves when taken
      if ((state_q == S_EMIT) && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && (kind_i == lbfg_pkg::KindSample)) begin
            state_q <= S_SUM;
          end
        end
        S_SUM:  state_q <= S_ADJ;
        S_ADJ:  state_q <= S_DIFF;
        S_DIFF: state_q <= S_MUL;
        S_MUL: begin
          div_q   <= lbfg_pkg::DivCntW'(lbfg_pkg::DivSteps - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_q == '0) begin
            state_q <= S_IDEAL;
          end else begin
            div_q <= div_q - 1'b1;
          end
        end
        S_IDEAL: state_q <= S_DIR;
        S_DIR:   state_q <= S_REQ;
        S_REQ:   state_q <= S_CLAMP;
        S_CLAMP: state_q <= S_EMIT;
        S_EMIT: begin
          if (!sts_i.has_req || emit_ok) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/lbfg_dp.sv
// datapath for the frequency governor
// holds config, governor state, the sample, a restoring divider and the output word
// depends on lbfg_pkg
module lbfg_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lbfg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lbfg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [lbfg_pkg::UsW-1:0]       wall_us_i,
  input  logic [lbfg_pkg::UsW-1:0]       idle_us_i,
  input  logic [lbfg_pkg::UsW-1:0]       iowait_us_i,
  input  logic [lbfg_pkg::UsW-1:0]       nice_us_i,
  input  logic [lbfg_pkg::KhzW-1:0]      cur_khz_i,
  input  logic [lbfg_pkg::UsW-1:0]       now_us_i,
  input  logic                           busy_tasks_i,
  input  logic                           suspended_i,
  input  lbfg_pkg::cmd_t                 cmd_i,
  output lbfg_pkg::sts_t                 sts_o,
  output logic [lbfg_pkg::KhzW-1:0]      target_khz_o,
  output logic                           relation_high_o,
  output logic [lbfg_pkg::PctW-1:0]      load_pct_o
);

  localparam int unsigned KhzW = lbfg_pkg::KhzW;
  localparam int unsigned UsW  = lbfg_pkg::UsW;
  localparam int unsigned PctW = lbfg_pkg::PctW;
  localparam int unsigned NumW = lbfg_pkg::NumW;
  localparam int unsigned ReqW = lbfg_pkg::ReqW;

  // config
  logic [KhzW-1:0]           pmin_q, pmax_q, up_step_q;
  logic [PctW-1:0]           up_pct_q, dn_pct_q;
  logic [lbfg_pkg::HoldW-1:0] dn_hold_q;
  logic                      iow_busy_q, nice_idle_q;

  // governor state
  logic [1:0]     boost_q;
  logic [UsW-1:0] last_q;

  // sample and work registers
  logic [UsW-1:0]  wall_q, iow_q, nice_q, now_q, diff_q, since_q;
  logic [UsW:0]    idle_q;
  logic [KhzW-1:0] cur_q, ideal_q, tgt_q;
  logic            busy_q, susp_q, ok_q, up_q, dn_q, rel_q, has_q;
  logic [NumW-1:0] num_q;
  logic [PctW-1:0] quo_q, load_q;
  logic signed [ReqW-1:0] req_q;

  // output word
  logic [KhzW-1:0] out_tgt_q;
  logic            out_rel_q;
  logic [PctW-1:0] out_load_q;

  // mode selected values
  logic [PctW-1:0] up_th, dn_th;
  logic [KhzW-1:0] dn_step, ideal_k;
  logic [UsW-1:0]  up_hold;

  logic [NumW-1:0] den;
  logic [KhzW:0]   up_sum;
  logic signed [ReqW-1:0] cur_s, floor_s, fl, clamped, pmin_s, pmax_s;
  logic [1:0]      boost_nx;

  assign up_th   = susp_q ? lbfg_pkg::SleepUpPct       : up_pct_q;
  assign dn_th   = susp_q ? lbfg_pkg::SleepDownPct     : dn_pct_q;
  assign dn_step = susp_q ? lbfg_pkg::SleepDownStepKhz : lbfg_pkg::AwakeDownStepKhz;
  assign up_hold = susp_q ? lbfg_pkg::SleepUpHoldUs    : lbfg_pkg::AwakeUpHoldUs;
  assign ideal_k = susp_q ? lbfg_pkg::SleepIdealKhz    : lbfg_pkg::AwakeIdealKhz;

  assign den     = NumW'(wall_q) << cmd_i.div_sh;
  assign up_sum  = {1'b0, cur_q} + {1'b0, up_step_q};
  assign cur_s   = $signed({2'b00, cur_q});
  assign pmin_s  = $signed({2'b00, pmin_q});
  assign pmax_s  = $signed({2'b00, pmax_q});
  assign floor_s = $signed({2'b00, lbfg_pkg::BoostFloorKhz});

  // boost sequence on a sample: 1 goes to 2 when awake, anything else ends it
  assign boost_nx = (!susp_q && (boost_q == 2'd1)) ? 2'd2 : 2'd0;

  always_comb begin
    fl = req_q;
    if ((req_q < floor_s) && (boost_q != 2'd0) && !susp_q) begin
      fl = floor_s;
    end
    priority if (fl > pmax_s) begin
      clamped = pmax_s;
    end else if (fl < pmin_s) begin
      clamped = pmin_s;
    end else begin
      clamped = fl;
    end
  end

  assign sts_o.has_req = has_q;

  assign target_khz_o    = out_tgt_q;
  assign relation_high_o = out_rel_q;
  assign load_pct_o      = out_load_q;

  // config and governor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmin_q      <= lbfg_pkg::RstPolicyMin;
      pmax_q      <= lbfg_pkg::RstPolicyMax;
      up_pct_q    <= lbfg_pkg::RstUpPct;
      dn_pct_q    <= lbfg_pkg::RstDownPct;
      up_step_q   <= lbfg_pkg::RstUpStep;
      dn_hold_q   <= lbfg_pkg::RstDownHold;
      iow_busy_q  <= 1'b1;
      nice_idle_q <= 1'b1;
      boost_q     <= 2'd0;
      last_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lbfg_pkg::CfgPolicyMin: pmin_q      <= cfg_wdata_i[KhzW-1:0];
          lbfg_pkg::CfgPolicyMax: pmax_q      <= cfg_wdata_i[KhzW-1:0];
          lbfg_pkg::CfgUpPct:     up_pct_q    <= cfg_wdata_i[PctW-1:0];
          lbfg_pkg::CfgDownPct:   dn_pct_q    <= cfg_wdata_i[PctW-1:0];
          lbfg_pkg::CfgUpStep:    up_step_q   <= cfg_wdata_i[KhzW-1:0];
          lbfg_pkg::CfgDownHold:  dn_hold_q   <= cfg_wdata_i[lbfg_pkg::HoldW-1:0];
          lbfg_pkg::CfgIowBusy:   iow_busy_q  <= cfg_wdata_i[0];
          lbfg_pkg::CfgNiceIdle:  nice_idle_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if ((cmd_i.op == lbfg_pkg::OP_EVENT) && !suspended_i) begin
        boost_q <= 2'd1;
      end else if (cmd_i.op == lbfg_pkg::OP_IDEAL) begin
        boost_q <= boost_nx;
      end
      if (cmd_i.op == lbfg_pkg::OP_EMIT) begin
        last_q <= now_q;
      end
    end
  end

  // sample datapath
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      lbfg_pkg::OP_LOAD: begin
        wall_q <= wall_us_i;
        idle_q <= {1'b0, idle_us_i};
        iow_q  <= iowait_us_i;
        nice_q <= nice_us_i;
        cur_q  <= cur_khz_i;
        now_q  <= now_us_i;
        busy_q <= busy_tasks_i;
        susp_q <= suspended_i;
      end
      lbfg_pkg::OP_SUM: begin
        if (nice_idle_q) begin
          idle_q <= idle_q + {1'b0, nice_q};
        end
      end
      lbfg_pkg::OP_ADJ: begin
        if (iow_busy_q && (idle_q >= {1'b0, iow_q})) begin
          idle_q <= idle_q - {1'b0, iow_q};
        end
      end
      lbfg_pkg::OP_DIFF: begin
        ok_q   <= (wall_q != '0) && ({1'b0, wall_q} >= idle_q);
        diff_q <= wall_q - idle_q[UsW-1:0];
      end
      lbfg_pkg::OP_MUL: begin
        // times 100 as 64 + 32 + 4
        num_q <= (NumW'(diff_q) << 6) + (NumW'(diff_q) << 5) + (NumW'(diff_q) << 2);
        quo_q <= '0;
      end
      lbfg_pkg::OP_DIV: begin
        if (num_q >= den) begin
          num_q               <= num_q - den;
          quo_q[cmd_i.div_sh] <= 1'b1;
        end
      end
      lbfg_pkg::OP_IDEAL: begin
        load_q  <= ok_q ? quo_q : '0;
        since_q <= now_q - last_q;
        if (pmin_q < ideal_k) begin
          ideal_q <= (ideal_k < pmax_q) ? ideal_k : pmax_q;
        end else begin
          ideal_q <= pmin_q;
        end
      end
      lbfg_pkg::OP_DIR: begin
        up_q <= (load_q > up_th) && (cur_q < pmax_q) &&
                ((cur_q < ideal_q) || (since_q >= up_hold));
        dn_q <= (load_q < dn_th) && (cur_q > pmin_q) &&
                ((cur_q > ideal_q) || (since_q >= UsW'(dn_hold_q)));
      end
      lbfg_pkg::OP_REQ: begin
        req_q <= '0;
        rel_q <= 1'b0;
        if (up_q) begin
          if (busy_q) begin
            if (cur_q < ideal_q) begin
              req_q <= $signed({2'b00, ideal_q});
            end else if (up_step_q != '0) begin
              rel_q <= 1'b1;
              if (up_sum > {1'b0, lbfg_pkg::AwakeIdealKhz}) begin
                req_q <= pmax_s;
              end else begin
                req_q <= $signed({1'b0, up_sum});
              end
            end
          end
        end else if (dn_q) begin
          if (cur_q > ideal_q) begin
            req_q <= $signed({2'b00, ideal_q});
            rel_q <= 1'b1;
          end else begin
            req_q <= cur_s - $signed({2'b00, dn_step});
          end
        end
      end
      lbfg_pkg::OP_CLAMP: begin
        has_q <= (up_q || dn_q) && (fl != '0) && (fl != cur_s) && (clamped != cur_s);
        tgt_q <= clamped[KhzW-1:0];
      end
      lbfg_pkg::OP_EMIT: begin
        out_tgt_q  <= tgt_q;
        out_rel_q  <= rel_q;
        out_load_q <= load_q;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/load_based_frequency_governor_unit.sv
// top level of the load based frequency governor
// joins the sequencer (lbfg_ctrl) and the datapath (lbfg_dp)
// depends on lbfg_pkg, lbfg_ctrl, lbfg_dp
//
// channel   direction  handshake                    word
// --------  ---------  ---------------------------  ----------------------------------------
// in        input      in_valid_i / in_stall_o      kind, wall, idle, iowait, nice, cur, now,
//                                                   busy_tasks, suspended
// out       output     out_valid_o / out_stall_i    target_khz, relation_high, load_pct
// cfg       input      cfg_we_i, cfg_idx_i          cfg_wdata_i, no read-back
//
// a load sample runs from accept until the next word is taken through the sum, iowait,
// difference and scaling steps, 7 restoring divide steps (one quotient bit each, set by
// the 7-bit load range), the ideal, direction, request and clamp steps and the emit step
// an input event word is absorbed in its accept cycle and never stalls the input
// reset (rst_ni low, asynchronous) loads the default policy and clears boost and the
// last change timestamp
// a finished result sits in the output register while the next sample is worked on;
// only a second result waits in the emit step while out_stall_i holds the first one
module load_based_frequency_governor_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [lbfg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lbfg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // sample channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [lbfg_pkg::UsW-1:0]       wall_us_i,
  input  logic [lbfg_pkg::UsW-1:0]       idle_us_i,
  input  logic [lbfg_pkg::UsW-1:0]       iowait_us_i,
  input  logic [lbfg_pkg::UsW-1:0]       nice_us_i,
  input  logic [lbfg_pkg::KhzW-1:0]      cur_khz_i,
  input  logic [lbfg_pkg::UsW-1:0]       now_us_i,
  input  logic                           busy_tasks_i,
  input  logic                           suspended_i,
  // target channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lbfg_pkg::KhzW-1:0]      target_khz_o,
  output logic                           relation_high_o,
  output logic [lbfg_pkg::PctW-1:0]      load_pct_o
);

  // command from the sequencer, status back from the datapath
  lbfg_pkg::cmd_t cmd;
  lbfg_pkg::sts_t sts;

  // sequencer: input stall, output valid and the step sequence
  lbfg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: config, boost and timestamp state, load divider and ramp decision
  lbfg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .wall_us_i       (wall_us_i),
    .idle_us_i       (idle_us_i),
    .iowait_us_i     (iowait_us_i),
    .nice_us_i       (nice_us_i),
    .cur_khz_i       (cur_khz_i),
    .now_us_i        (now_us_i),
    .busy_tasks_i    (busy_tasks_i),
    .suspended_i     (suspended_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .target_khz_o    (target_khz_o),
    .relation_high_o (relation_high_o),
    .load_pct_o      (load_pct_o)
  );

  // a load sample holds off the next word while it is worked on
  a_sample_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (kind_i == lbfg_pkg::KindSample)) |=> in_stall_o)
    else $error("sample accepted without stalling the input");

  // an input event is absorbed at once
  a_event_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (kind_i == lbfg_pkg::KindEvent)) |=> !in_stall_o)
    else $error("input event stalled the input");

  // measured load never exceeds full scale
  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (load_pct_o <= lbfg_pkg::FullPct))
    else $error("load percent out of range");

  // a new result only appears when the sequencer leaves its emit step
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result raised outside the emit step");

endmodule
